### rtl/core/spi_lsb_first_frame_master_top_defines.svh
// Assertion macros shared by the serial frame master RTL.
// Included by files that check their own sequencing; no other dependencies.
`ifndef SPI_LSB_FIRST_FRAME_MASTER_TOP_DEFINES_SVH
`define SPI_LSB_FIRST_FRAME_MASTER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define SLFM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define SLFM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SLFM_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SLFM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/core/slfm_pkg.sv
// Shared types and constants of the serial frame master.
// No dependencies; imported by the configuration, sequencer and top modules.
package slfm_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam int PHASE_W    = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAD        = 1'b1;

    // Phase lengths as the sequencer sees them, never zero.
    typedef struct packed {
        logic [PHASE_W-1:0] half_period;
        logic [PHASE_W-1:0] lead;
    } t_cfg;

    // A programmed length of zero is read as a length of one.
    function automatic logic [PHASE_W-1:0] at_least_one(input logic [PHASE_W-1:0] value);
        at_least_one = (value == '0) ? PHASE_W'(1) : value;
    endfunction

endpackage

### rtl/core/slfm_cfg.sv
// Configuration registers of the serial frame master (phase lengths).
// Depends on slfm_pkg.
module slfm_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_write,
    input  logic [slfm_pkg::CFG_IDX_W-1:0]  i_index,
    input  logic [slfm_pkg::CFG_DATA_W-1:0] i_data,
    output slfm_pkg::t_cfg                  o_cfg
);
    import slfm_pkg::*;

    logic [PHASE_W-1:0] r_half_period;
    logic [PHASE_W-1:0] r_lead;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= PHASE_W'(1);
            r_lead        <= PHASE_W'(1);
        end else if (i_write) begin
            unique case (i_index)
                CFG_HALF_PERIOD: r_half_period <= i_data;
                CFG_LEAD:        r_lead        <= i_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg.half_period = at_least_one(r_half_period);
    assign o_cfg.lead        = at_least_one(r_lead);

endmodule

### rtl/core/slfm_seq.sv
// Frame sequencer: one tick per accepted transaction, producing pin levels and status.
// Depends on slfm_pkg and the assertion macro header.
`include "spi_lsb_first_frame_master_top_defines.svh"
module slfm_seq #(
    parameter int ADDR_BITS = 6,
    parameter int DATA_BITS = 16,
    parameter int IN_W      = 32,
    parameter int OUT_W     = 24
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  slfm_pkg::t_cfg   i_cfg,
    input  logic [IN_W-1:0]  i_item,
    output logic [OUT_W-1:0] o_result
);
    import slfm_pkg::*;

    localparam int FRAME_BITS = ADDR_BITS + 2 + DATA_BITS;
    localparam int DATA_START = ADDR_BITS + 2;
    localparam int IDX_W      = $clog2(FRAME_BITS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEAD,
        ST_LOW,
        ST_HIGH,
        ST_DONE
    } t_stage;

    t_stage                r_stage,     n_stage;
    logic [IDX_W-1:0]      r_bit_index, n_bit_index;
    logic [PHASE_W-1:0]    r_phase,     n_phase;
    logic [FRAME_BITS-1:0] r_out_shift, n_out_shift;
    logic [DATA_BITS-1:0]  r_in_word,   n_in_word;
    logic                  r_is_read,   n_is_read;

    logic                  start_req;
    logic                  cmd;
    logic [ADDR_BITS-1:0]  reg_addr;
    logic [DATA_BITS-1:0]  write_data;
    logic                  miso_in;
    logic                  sample;
    logic [FRAME_BITS-1:0] frame;
    logic                  sel, sending, done;

    assign start_req  = i_item[0];
    assign cmd        = i_item[1];
    assign reg_addr   = i_item[2 +: ADDR_BITS];
    assign write_data = i_item[2 + ADDR_BITS +: DATA_BITS];
    assign miso_in    = i_item[2 + ADDR_BITS + DATA_BITS];

    always_comb begin
        frame                 = '0;
        frame[ADDR_BITS-1:0]  = reg_addr;
        frame[ADDR_BITS]      = cmd;
        if (!cmd) begin
            frame[DATA_START +: DATA_BITS] = write_data;
        end
    end

    always_comb begin
        n_stage     = r_stage;
        n_bit_index = r_bit_index;
        n_phase     = r_phase;
        n_out_shift = r_out_shift;
        n_in_word   = r_in_word;
        n_is_read   = r_is_read;
        sample      = 1'b0;
        unique case (r_stage)
            ST_LEAD: begin
                if (r_phase >= i_cfg.lead) begin
                    n_stage = ST_LOW;
                    n_phase = PHASE_W'(1);
                    sample  = 1'b1;
                end else begin
                    n_phase = r_phase + 1'b1;
                end
            end
            ST_LOW: begin
                if (r_phase >= i_cfg.half_period) begin
                    n_stage = ST_HIGH;
                    n_phase = PHASE_W'(1);
                end else begin
                    n_phase = r_phase + 1'b1;
                end
            end
            ST_HIGH: begin
                if (r_phase >= i_cfg.half_period) begin
                    n_bit_index = r_bit_index + 1'b1;
                    n_out_shift = r_out_shift >> 1;
                    if (n_bit_index >= IDX_W'(FRAME_BITS)) begin
                        n_stage = ST_DONE;
                        n_phase = '0;
                    end else begin
                        n_stage = ST_LOW;
                        n_phase = PHASE_W'(1);
                        sample  = 1'b1;
                    end
                end else begin
                    n_phase = r_phase + 1'b1;
                end
            end
            ST_DONE: begin
                n_stage = ST_IDLE;
                n_phase = '0;
            end
            default: begin
                n_stage = ST_IDLE;
                if (start_req) begin
                    n_out_shift = frame;
                    n_is_read   = cmd;
                    n_in_word   = '0;
                    n_bit_index = '0;
                    n_phase     = PHASE_W'(1);
                    n_stage     = ST_LEAD;
                end
            end
        endcase
        // Data bits are sampled in order, so the word fills from the top down.
        if (sample && r_is_read && n_bit_index >= IDX_W'(DATA_START)) begin
            n_in_word = {miso_in, r_in_word[DATA_BITS-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage     <= ST_IDLE;
            r_bit_index <= '0;
            r_phase     <= '0;
            r_out_shift <= '0;
            r_in_word   <= '0;
            r_is_read   <= 1'b0;
        end else if (i_accept) begin
            r_stage     <= n_stage;
            r_bit_index <= n_bit_index;
            r_phase     <= n_phase;
            r_out_shift <= n_out_shift;
            r_in_word   <= n_in_word;
            r_is_read   <= n_is_read;
        end
    end

    assign sel     = (n_stage == ST_LEAD) || (n_stage == ST_LOW) || (n_stage == ST_HIGH);
    assign sending = (n_stage == ST_LOW) || (n_stage == ST_HIGH);
    assign done    = (n_stage == ST_DONE);

    always_comb begin
        o_result                 = '0;
        o_result[0]              = sel;
        o_result[1]              = (n_stage != ST_LOW);
        o_result[2]              = sending & n_out_shift[0];
        o_result[3]              = (n_stage != ST_IDLE);
        o_result[4]              = done;
        o_result[5 +: DATA_BITS] = (done && n_is_read) ? n_in_word : '0;
    end

    `SLFM_ASSERT_NEXT(a_done_returns_idle, i_clk, i_rst_n,
        i_accept && (r_stage == ST_DONE), r_stage == ST_IDLE)
    `SLFM_ASSERT_NOW(a_bit_index_in_frame, i_clk, i_rst_n,
        1'b1, r_bit_index <= IDX_W'(FRAME_BITS))
    `SLFM_ASSERT_NOW(a_done_deselected, i_clk, i_rst_n,
        done, !sel && o_result[1])
    `SLFM_ASSERT_NEXT(a_hold_without_accept, i_clk, i_rst_n,
        !i_accept, $stable(r_stage) && $stable(r_bit_index) && $stable(r_in_word))

endmodule

### rtl/core/slfm_oreg.sv
// Result register of the serial frame master; parts input acceptance from output stalls.
// Generic over the result width; no dependencies.
module slfm_oreg #(
    parameter int W = 24
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [W-1:0] o_data
);
    logic         r_valid;
    logic [W-1:0] r_data;

    // A held result that is being taken frees the register for a new one.
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### rtl/core/spi_lsb_first_frame_master_top.sv
// Serial frame master, one input transaction per clock tick unless the output stalls, one result per transaction.
// A result appears on the master side in the cycle after its input is accepted.
// Throughput: one transaction per cycle while results are taken; a master-side stall holds both.
// A frame runs the lead phase, a low and a high half period per frame bit, then the done stage.
// Reset (synchronous, active low) returns the sequencer to idle and both phase lengths to 1.
module spi_lsb_first_frame_master_top #(
    parameter int ADDR_BITS = 6,
    parameter int DATA_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // start_req, cmd, reg_addr, write_data, miso_in (low bit up), zero padded
    input  logic [((ADDR_BITS+DATA_BITS+3+7)/8)*8-1:0] i_s_axis_tdata,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // select_out, sclk_out, mosi_out, busy_res, done_res, read_data (low bit up), zero padded
    output logic [((DATA_BITS+5+7)/8)*8-1:0] o_m_axis_tdata,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [slfm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [slfm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import slfm_pkg::*;

    localparam int IN_W  = ((ADDR_BITS + DATA_BITS + 3 + 7) / 8) * 8;
    localparam int OUT_W = ((DATA_BITS + 5 + 7) / 8) * 8;

    t_cfg             cfg;
    logic             accept;
    logic [OUT_W-1:0] result;

    assign o_cfg_ready = 1'b1;
    assign accept      = i_s_axis_tvalid && o_s_axis_tready;

    slfm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_write (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    slfm_seq #(
        .ADDR_BITS (ADDR_BITS),
        .DATA_BITS (DATA_BITS),
        .IN_W      (IN_W),
        .OUT_W     (OUT_W)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_cfg    (cfg),
        .i_item   (i_s_axis_tdata),
        .o_result (result)
    );

    slfm_oreg #(
        .W (OUT_W)
    ) u_oreg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_data  (result),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata)
    );

endmodule
